// File: hw/rtl/float_frexp_unit_top_macros.svh
// Assertion helpers, clocked on i_clk and disabled while reset is held.
`ifndef FLOAT_FREXP_UNIT_TOP_MACROS_SVH
`define FLOAT_FREXP_UNIT_TOP_MACROS_SVH

// Same-cycle implication.
`define FFU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ffu_pkg.sv
package ffu_pkg;
    localparam int DATA_W = 64;
    localparam int DBL_FW = 52;
    localparam int DBL_EW = 11;
    localparam int SGL_FW = 23;
    localparam int SGL_EW = 8;
    localparam int SGL_W  = SGL_FW + SGL_EW + 1;
    localparam logic MODE_DOUBLE = 1'b0;
    localparam logic MODE_SINGLE = 1'b1;
endpackage

// File: hw/rtl/float_frexp_unit_top.sv
// frexp unit: splits a double, or a single held in the low 32 bits, into a
// signed mantissa of magnitude [0.5,1) and an exponent coded as a float of the
// same precision. One transaction per cycle unless the downstream stall backs up
// the pipe; each passes through the input register and the result register
// around the split logic. Zero, NaN and infinity pass through with a +0.0
// exponent. Single results have zero upper halves.
`include "float_frexp_unit_top_macros.svh"

module float_frexp_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [63:0] i_value_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_mantissa_bits,
    output logic [63:0] o_exponent_bits
);
    localparam int DW = ffu_pkg::DATA_W;
    localparam int SW = ffu_pkg::SGL_W;

    logic          r_s1_valid, n_s1_valid;
    logic          r_s1_mode;
    logic [DW-1:0] r_s1_bits;
    logic          r_s2_valid, n_s2_valid;
    logic          r_s2_mode;
    logic [DW-1:0] r_s2_mant;
    logic [DW-1:0] r_s2_expo;
    logic          s2_load;
    logic          s1_load;
    logic [DW-1:0] d_mant, d_expo;
    logic [SW-1:0] s_mant, s_expo;
    logic [DW-1:0] mant, expo;

    assign s2_load = !r_s2_valid || !i_stall;
    assign o_stall = r_s1_valid && !s2_load;
    assign s1_load = !o_stall;

    assign n_s1_valid = s1_load ? i_valid : r_s1_valid;
    assign n_s2_valid = s2_load ? r_s1_valid : r_s2_valid;

    ffu_split #(.FW(ffu_pkg::DBL_FW), .EW(ffu_pkg::DBL_EW)) u_dbl (
        .i_bits(r_s1_bits), .o_mant(d_mant), .o_expo(d_expo)
    );
    ffu_split #(.FW(ffu_pkg::SGL_FW), .EW(ffu_pkg::SGL_EW)) u_sgl (
        .i_bits(r_s1_bits[SW-1:0]), .o_mant(s_mant), .o_expo(s_expo)
    );

    always_comb begin
        if (r_s1_mode == ffu_pkg::MODE_SINGLE) begin
            mant = DW'(s_mant);
            expo = DW'(s_expo);
        end else begin
            mant = d_mant;
            expo = d_expo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_mode <= i_mode;
            r_s1_bits <= i_value_bits;
        end
        if (s2_load) begin
            r_s2_mode <= r_s1_mode;
            r_s2_mant <= mant;
            r_s2_expo <= expo;
        end
    end

    assign o_valid         = r_s2_valid;
    assign o_mantissa_bits = r_s2_mant;
    assign o_exponent_bits = r_s2_expo;

    `FFU_ASSERT_IMP(a_stall_needs_full, o_stall,
        r_s1_valid && r_s2_valid && i_stall, "stall without full pipe")
    `FFU_ASSERT_NXT(a_drain, r_s2_valid && !i_stall && !r_s1_valid, !o_valid,
        "result repeated")
    `FFU_ASSERT_NXT(a_fill, r_s1_valid && !o_stall, o_valid, "result lost")
    `FFU_ASSERT_IMP(a_single_upper, o_valid && r_s2_mode == ffu_pkg::MODE_SINGLE,
        o_mantissa_bits[63:32] == '0 && o_exponent_bits[63:32] == '0,
        "single upper half set")
endmodule

// File: hw/rtl/ffu_lzc.sv
// Position of the highest set bit; zero for a zero input.
module ffu_lzc #(
    parameter int W = 52
) (
    input  logic [W-1:0]         i_data,
    output logic [$clog2(W)-1:0] o_pos
);
    always_comb begin
        o_pos = '0;
        for (int i = 0; i < W; i++) begin
            if (i_data[i]) begin
                o_pos = ($clog2(W))'(i);
            end
        end
    end
endmodule

// File: hw/rtl/ffu_split.sv
// frexp split for one IEEE format.
module ffu_split #(
    parameter int FW = 52,
    parameter int EW = 11
) (
    input  logic [FW+EW:0] i_bits,
    output logic [FW+EW:0] o_mant,
    output logic [FW+EW:0] o_expo
);
    localparam int BIAS    = 2 ** (EW - 1) - 1;
    localparam int SUB_OFF = BIAS + FW - 2;
    localparam int PW      = $clog2(FW);
    localparam int QW      = $clog2(EW + 1);

    logic          sign;
    logic [EW-1:0] ef;
    logic [FW-1:0] frac;
    logic [PW-1:0] p;
    logic          pass;
    logic signed [EW:0] e;
    logic [EW:0]   mag;
    logic [QW-1:0] q;
    logic [FW-1:0] frac_n;
    logic [FW-1:0] frac_e;
    logic [EW-1:0] field_e;

    assign sign = i_bits[FW+EW];
    assign ef   = i_bits[FW+EW-1:FW];
    assign frac = i_bits[FW-1:0];
    assign pass = (ef == {EW{1'b1}}) || (ef == '0 && frac == '0);

    ffu_lzc #(.W(FW)) u_frac_lzc (.i_data(frac), .o_pos(p));

    always_comb begin
        if (ef == '0) begin
            e      = $signed((EW+1)'(p)) - $signed((EW+1)'(SUB_OFF));
            frac_n = FW'(frac << (FW - int'(p)));
        end else begin
            e      = $signed({1'b0, ef}) - $signed((EW+1)'(BIAS - 1));
            frac_n = frac;
        end
        mag = e[EW] ? (EW+1)'(-e) : e;
    end

    ffu_lzc #(.W(EW+1)) u_mag_lzc (.i_data(mag), .o_pos(q));

    assign field_e = EW'(BIAS) + EW'(q);
    assign frac_e  = FW'(((FW+EW+1)'(mag)) << (FW - int'(q)));

    always_comb begin
        if (pass) begin
            o_mant = i_bits;
            o_expo = '0;
        end else begin
            o_mant = {sign, EW'(BIAS - 1), frac_n};
            if (e == '0) begin
                o_expo = '0;
            end else begin
                o_expo = {e[EW], field_e, frac_e};
            end
        end
    end
endmodule

// File: dv/float_frexp_unit_top_tb.sv
module float_frexp_unit_top_tb;

    typedef struct packed {
        logic        mode;
        logic [63:0] value;
    } t_frexp_in;

    typedef struct packed {
        logic [63:0] mant;
        logic [63:0] expo;
    } t_frexp_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_mode;
    logic [63:0] i_value_bits;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_mantissa_bits;
    logic [63:0] o_exponent_bits;

    float_frexp_unit_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_value_bits(i_value_bits), .o_valid(o_valid),
        .i_stall(i_stall), .o_mantissa_bits(o_mantissa_bits),
        .o_exponent_bits(o_exponent_bits)
    );

    t_frexp_in  pending_items[$];
    t_frexp_out split_expected[$];
    int         mismatch_cnt;
    int         result_cnt;
    int         special_cnt;
    int         single_cnt;
    bit         stim_done;
    bit         hold_for_drain;
    int         tx_gap;
    int         rx_gap;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Integer exponent as IEEE pattern of the chosen precision.
    function automatic logic [63:0] int_to_float(int e, int fw, int ew);
        logic [63:0] mag;
        logic [63:0] frac;
        logic [63:0] sgn;
        int          q;
        if (e == 0) return 64'd0;
        sgn = (e < 0) ? 64'd1 : 64'd0;
        mag = (e < 0) ? 64'(-e) : 64'(e);
        q = 0;
        for (int b = 0; b < 64; b++) if (mag[b]) q = b;
        frac = (mag << (fw - q)) & ((64'd1 << fw) - 1);
        return (sgn << (fw + ew)) | (64'((1 << (ew - 1)) - 1 + q) << fw) | frac;
    endfunction

    function automatic t_frexp_out frexp_split(t_frexp_in it);
        t_frexp_out  r;
        logic [63:0] bits;
        logic [63:0] fmask;
        logic [63:0] emax;
        logic [63:0] ef;
        logic [63:0] frac;
        logic [63:0] sgn;
        int          fw;
        int          ew;
        int          bias;
        int          e;
        int          p;
        fw = (it.mode == ffu_pkg::MODE_SINGLE) ? ffu_pkg::SGL_FW : ffu_pkg::DBL_FW;
        ew = (it.mode == ffu_pkg::MODE_SINGLE) ? ffu_pkg::SGL_EW : ffu_pkg::DBL_EW;
        bits = (it.mode == ffu_pkg::MODE_SINGLE) ? {32'd0, it.value[31:0]} : it.value;
        fmask = (64'd1 << fw) - 1;
        emax = (64'd1 << ew) - 1;
        bias = (1 << (ew - 1)) - 1;
        sgn = (bits >> (fw + ew)) & 64'd1;
        ef = (bits >> fw) & emax;
        frac = bits & fmask;
        if (ef == emax || (ef == 0 && frac == 0)) begin
            r.mant = bits;
            r.expo = 64'd0;
            return r;
        end
        if (ef == 0) begin
            p = 0;
            for (int b = 0; b < 64; b++) if (frac[b]) p = b;
            e = p + 2 - bias - fw;
            frac = (frac << (fw - p)) & fmask;
        end else begin
            e = int'(ef) - (bias - 1);
        end
        r.mant = (sgn << (fw + ew)) | (64'(bias - 1) << fw) | frac;
        r.expo = int_to_float(e, fw, ew);
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random idle gap after a transaction, zero at least half of the time.
    function automatic int draw_gap();
        return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 8));
    endfunction

    // Random value biased toward the interesting exponent codes.
    function automatic t_frexp_in rand_item();
        t_frexp_in it;
        int        k;
        it.mode = 1'($urandom_range(0, 1));
        it.value = rand64();
        k = $urandom_range(0, 9);
        if (it.mode == ffu_pkg::MODE_DOUBLE) begin
            case (k)
                0: it.value[62:52] = '0;
                1: it.value[62:52] = '1;
                2: it.value[62:0] = '0;
                3: it.value[62:52] = 11'd1022;
                4: it.value[51:0] = 52'(1) << $urandom_range(0, 51);
                default: ;
            endcase
        end else begin
            case (k)
                0: it.value[30:23] = '0;
                1: it.value[30:23] = '1;
                2: it.value[30:0] = '0;
                3: it.value[30:23] = 8'd126;
                4: it.value[22:0] = 23'(1) << $urandom_range(0, 22);
                default: ;
            endcase
        end
        return it;
    endfunction

    function automatic t_frexp_in mk(logic m, logic [63:0] v);
        t_frexp_in it;
        it.mode = m;
        it.value = v;
        return it;
    endfunction

    function automatic void queue_item(t_frexp_in it);
        pending_items = {pending_items, it};
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (hold_for_drain || pending_items.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                t_frexp_in it;
                it = pending_items.pop_front();
                i_valid <= 1'b1;
                i_mode <= it.mode;
                i_value_bits <= it.value;
                tx_gap <= draw_gap();
                split_expected = {split_expected, frexp_split(it)};
                if (it.mode == ffu_pkg::MODE_SINGLE) single_cnt++;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap <= 0;
        end else if (o_valid && !i_stall) begin
            t_frexp_out exp_r;
            int         gap;
            result_cnt++;
            if (split_expected.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result mant=%h expo=%h",
                             o_mantissa_bits, o_exponent_bits);
            end else begin
                exp_r = split_expected.pop_front();
                if (exp_r.mant != o_mantissa_bits || exp_r.expo != o_exponent_bits) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: mant exp %h got %h, expo exp %h got %h",
                                 exp_r.mant, o_mantissa_bits, exp_r.expo,
                                 o_exponent_bits);
                end
            end
            gap = draw_gap();
            i_stall <= (gap > 0);
            rx_gap <= (gap > 0) ? gap - 1 : 0;
        end else if (rx_gap > 0) begin
            i_stall <= 1'b1;
            rx_gap <= rx_gap - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        mismatch_cnt = 0;
        result_cnt = 0;
        special_cnt = 0;
        single_cnt = 0;
        stim_done = 1'b0;
        hold_for_drain = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_mode = ffu_pkg::MODE_DOUBLE;
        i_value_bits = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zeros, inf, nan, subnormal extremes, exponent zero, max
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h0000_0000_0000_0000));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h8000_0000_0000_0000));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h7FF0_0000_0000_0000));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'hFFF0_0000_0000_0000));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h7FF8_0000_0000_0001));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h0000_0000_0000_0001));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h800F_FFFF_FFFF_FFFF));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h3FE0_0000_0000_0000));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'hBFEF_FFFF_FFFF_FFFF));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h7FEF_FFFF_FFFF_FFFF));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h0010_0000_0000_0000));
        queue_item(mk(ffu_pkg::MODE_DOUBLE, 64'h3FF0_0000_0000_0000));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'hFFFF_FFFF_0000_0000));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'h1234_5678_8000_0000));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'h0000_0000_7F80_0000));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'hFFFF_FFFF_FFC0_0000));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'h0000_0000_0000_0001));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'hAAAA_AAAA_807F_FFFF));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'h0000_0000_3F00_0000));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'h5555_5555_7F7F_FFFF));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'h0000_0000_0080_0000));
        queue_item(mk(ffu_pkg::MODE_SINGLE, 64'hFFFF_FFFF_BF80_0000));
        special_cnt = pending_items.size();

        for (int n = 0; n < 650; n++) queue_item(rand_item());
        wait (pending_items.size() == 0);
        // drain completely once before the rest of the traffic
        hold_for_drain = 1'b1;
        wait (split_expected.size() == 0);
        repeat (4) @(posedge i_clk);
        hold_for_drain = 1'b0;
        for (int n = 0; n < 650; n++) queue_item(rand_item());
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        wait (split_expected.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("covered %0d directed and %0d random values, %0d in single precision",
                 special_cnt, result_cnt - special_cnt, single_cnt);
        $display("%0d results checked with %0d mismatches", result_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && split_expected.size() == 0)
            $display("float_frexp_unit_top verification clean");
        else
            $display("float_frexp_unit_top verification failed");
        $finish;
    end

    initial begin
        #400000;
        $display("float_frexp_unit_top verification failed");
        $finish;
    end
endmodule

// File: float_frexp_unit_top.f
+incdir+hw/rtl
hw/rtl/ffu_pkg.sv
hw/rtl/ffu_lzc.sv
hw/rtl/ffu_split.sv
hw/rtl/float_frexp_unit_top.sv
dv/float_frexp_unit_top_tb.sv
